// ----- hdl/rsa_pkg.sv -----
// Shared constants and types for the textbook RSA engine.
// No dependencies; imported by every rsa_* module.
package rsa_pkg;

  localparam int unsigned PRIME_WIDTH = 16;                 // significant bits of each prime
  localparam int unsigned KEY_W       = 32;                 // modulus, exponents, message
  localparam int unsigned CFG_PRIME_W = 16;                 // prime register width
  localparam int unsigned SGN_W       = KEY_W + 3;          // Bezout coefficient width
  localparam int unsigned CNT_W       = $clog2(KEY_W);
  localparam int unsigned PCNT_W      = $clog2(PRIME_WIDTH);
  localparam int unsigned ADDR_W      = 4;
  localparam int unsigned DATA_W      = 32;

  localparam logic [CNT_W-1:0]  CNT_MAX    = CNT_W'(KEY_W - 1);
  localparam logic [PCNT_W-1:0] PCNT_MAX   = PCNT_W'(PRIME_WIDTH - 1);
  localparam logic [KEY_W-1:0]  PRIME_MASK = KEY_W'((64'd1 << PRIME_WIDTH) - 64'd1);

  localparam logic [CFG_PRIME_W-1:0] RESET_PRIME_P = CFG_PRIME_W'(73);
  localparam logic [CFG_PRIME_W-1:0] RESET_PRIME_Q = CFG_PRIME_W'(227);
  localparam logic [KEY_W-1:0]       RESET_PUB_EXP = KEY_W'(29);

  // register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_PRIME_P = 2'd0;
  localparam logic [1:0] REG_PRIME_Q = 2'd1;
  localparam logic [1:0] REG_PUB_EXP = 2'd2;

  localparam logic MODE_ENCRYPT = 1'b0;
  localparam logic MODE_DECRYPT = 1'b1;

  // key derivation status toward the top level
  typedef struct packed {
    logic             busy;
    logic             inv_missing;
    logic [KEY_W-1:0] modulus;
    logic [KEY_W-1:0] priv_exp;
  } keys_t;

  // one exponentiation request
  typedef struct packed {
    logic [KEY_W-1:0] message;
    logic [KEY_W-1:0] exponent;
    logic [KEY_W-1:0] modulus;
    logic             zero;      // answer 0 without computing
  } exp_req_t;

endpackage

// ----- hdl/rsa_modmul.sv -----
// Bit-serial modular multiplier: a * b mod n, one bit of a per cycle, MSB first.
// Requires b < n. Depends on rsa_pkg.
module rsa_modmul import rsa_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [KEY_W-1:0] a_i,
  input  logic [KEY_W-1:0] b_i,
  input  logic [KEY_W-1:0] n_i,
  output logic             done_o,
  output logic [KEY_W-1:0] prod_o
);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [KEY_W-1:0] x_q, y_q, n_q, z_q;
  logic [KEY_W:0]   n2_q;
  logic [KEY_W+1:0] t_sum, t_n1, t_n2, t_sel;

  // z < n and y < n, so 2z + y < 3n: at most two subtractions of n
  assign t_sum = {1'b0, z_q, 1'b0} + (x_q[KEY_W-1] ? {2'b00, y_q} : '0);
  assign t_n1  = {2'b00, n_q};
  assign t_n2  = {1'b0, n2_q};

  always_comb begin
    if (t_sum >= t_n2) begin
      t_sel = t_sum - t_n2;
    end else if (t_sum >= t_n1) begin
      t_sel = t_sum - t_n1;
    end else begin
      t_sel = t_sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_MAX) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q  <= a_i;
      y_q  <= b_i;
      n_q  <= n_i;
      n2_q <= {n_i, 1'b0};
      z_q  <= '0;
    end else if (busy_q) begin
      z_q <= t_sel[KEY_W-1:0];
      x_q <= {x_q[KEY_W-2:0], 1'b0};
    end
  end

  assign done_o = done_q;
  assign prod_o = z_q;

endmodule

// ----- hdl/rsa_keygen.sv -----
// Key derivation: n = p*q and phi by shift-add, then d = e^-1 mod phi by the
// extended Euclidean algorithm with a bit-serial divider. Depends on rsa_pkg.
module rsa_keygen import rsa_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [CFG_PRIME_W-1:0] prime_p_i,
  input  logic [CFG_PRIME_W-1:0] prime_q_i,
  input  logic [KEY_W-1:0]       pub_exp_i,
  output keys_t                  keys_o
);

  typedef enum logic [2:0] {KG_IDLE, KG_MUL, KG_DIV, KG_FIN, KG_FIX} kg_state_e;

  kg_state_e         state_q;
  logic [PCNT_W-1:0] pcnt_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [KEY_W-1:0]  modulus_q, priv_q;
  logic              inv_q;

  logic [KEY_W-1:0] mc_n_q, mpl_n_q, acc_n_q, mc_phi_q, mpl_phi_q, acc_phi_q;
  logic             zero_q;
  logic [KEY_W-1:0] phi_q, old_r_q, r_q, rem_q, dvd_q;
  logic signed [SGN_W-1:0] old_s_q, s_q, prod_q;

  logic [KEY_W-1:0] p_m, q_m, acc_n_sum, acc_phi_sum, phi_val, rem_step;
  logic [KEY_W:0]   rem_sh;
  logic             ge;
  logic signed [SGN_W-1:0] prod_step, new_s, phi_s, fold_s;

  assign p_m = KEY_W'(prime_p_i) & PRIME_MASK;
  assign q_m = KEY_W'(prime_q_i) & PRIME_MASK;

  assign acc_n_sum   = acc_n_q + (mpl_n_q[0] ? mc_n_q : '0);
  assign acc_phi_sum = acc_phi_q + (mpl_phi_q[0] ? mc_phi_q : '0);
  assign phi_val     = zero_q ? '0 : acc_phi_sum;

  // restoring division of old_r by r; quotient*s built by Horner alongside
  assign rem_sh    = {rem_q, dvd_q[KEY_W-1]};
  assign ge        = rem_sh >= {1'b0, r_q};
  assign rem_step  = ge ? KEY_W'(rem_sh - {1'b0, r_q}) : rem_sh[KEY_W-1:0];
  assign prod_step = (prod_q <<< 1) + (ge ? s_q : '0);
  assign new_s     = old_s_q - prod_step;

  assign phi_s  = $signed({{(SGN_W-KEY_W){1'b0}}, phi_q});
  assign fold_s = old_s_q[SGN_W-1] ? old_s_q + phi_s : old_s_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= KG_IDLE;
      pcnt_q    <= '0;
      cnt_q     <= '0;
      modulus_q <= '0;
      priv_q    <= '0;
      inv_q     <= 1'b0;
    end else if (start_i) begin
      state_q <= KG_MUL;
      pcnt_q  <= '0;
    end else begin
      unique case (state_q)
        KG_IDLE: ;
        KG_MUL: begin
          pcnt_q <= pcnt_q + 1'b1;
          if (pcnt_q == PCNT_MAX) begin
            modulus_q <= acc_n_sum;
            cnt_q     <= '0;
            if (phi_val == '0) begin
              priv_q  <= '0;
              inv_q   <= 1'b1;
              state_q <= KG_IDLE;
            end else begin
              state_q <= KG_DIV;
            end
          end
        end
        KG_DIV: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNT_MAX && rem_step == '0) begin
            state_q <= KG_FIN;
          end
        end
        KG_FIN: begin
          if (old_r_q == KEY_W'(1)) begin
            state_q <= KG_FIX;
          end else begin
            priv_q  <= '0;
            inv_q   <= 1'b1;
            state_q <= KG_IDLE;
          end
        end
        KG_FIX: begin
          // old_s already folded into [0, phi]; phi itself maps to 0
          priv_q  <= (old_s_q >= phi_s) ? KEY_W'(old_s_q - phi_s) : old_s_q[KEY_W-1:0];
          inv_q   <= 1'b0;
          state_q <= KG_IDLE;
        end
        default: state_q <= KG_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mc_n_q    <= p_m;
      mpl_n_q   <= q_m;
      mc_phi_q  <= p_m - 1'b1;
      mpl_phi_q <= q_m - 1'b1;
      acc_n_q   <= '0;
      acc_phi_q <= '0;
      zero_q    <= (p_m == '0) || (q_m == '0);
    end else begin
      case (state_q)
        KG_MUL: begin
          acc_n_q   <= acc_n_sum;
          acc_phi_q <= acc_phi_sum;
          mc_n_q    <= {mc_n_q[KEY_W-2:0], 1'b0};
          mc_phi_q  <= {mc_phi_q[KEY_W-2:0], 1'b0};
          mpl_n_q   <= {1'b0, mpl_n_q[KEY_W-1:1]};
          mpl_phi_q <= {1'b0, mpl_phi_q[KEY_W-1:1]};
          if (pcnt_q == PCNT_MAX) begin
            phi_q   <= phi_val;
            old_r_q <= pub_exp_i;
            r_q     <= phi_val;
            old_s_q <= SGN_W'(1);
            s_q     <= '0;
            dvd_q   <= pub_exp_i;
            rem_q   <= '0;
            prod_q  <= '0;
          end
        end
        KG_DIV: begin
          if (cnt_q == CNT_MAX) begin
            old_r_q <= r_q;
            r_q     <= rem_step;
            old_s_q <= s_q;
            s_q     <= new_s;
            dvd_q   <= r_q;
            rem_q   <= '0;
            prod_q  <= '0;
          end else begin
            rem_q  <= rem_step;
            prod_q <= prod_step;
            dvd_q  <= {dvd_q[KEY_W-2:0], 1'b0};
          end
        end
        KG_FIN: old_s_q <= fold_s;
        default: ;
      endcase
    end
  end

  assign keys_o.busy        = (state_q != KG_IDLE);
  assign keys_o.inv_missing = inv_q;
  assign keys_o.modulus     = modulus_q;
  assign keys_o.priv_exp    = priv_q;

endmodule

// ----- hdl/rsa_modexp.sv -----
// Modular exponentiation by right-to-left square and multiply, using two
// bit-serial multipliers in parallel. Depends on rsa_pkg and rsa_modmul.
module rsa_modexp import rsa_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  exp_req_t         req_i,
  output logic             idle_o,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output logic [KEY_W-1:0] result_o
);

  typedef enum logic [1:0] {ME_IDLE, ME_REDUCE, ME_EXP, ME_DONE} me_state_e;

  me_state_e        state_q;
  logic [CNT_W-1:0] cnt_q;
  logic [KEY_W-1:0] result_q;
  logic [KEY_W-1:0] acc_q, exp_q, n_q, one_q;

  logic             mm_start, mm0_done, mm1_done, mm_done;
  logic [KEY_W-1:0] mm0_a, mm0_b, mm1_a, mm1_b, mm_n, mm0_prod, mm1_prod;
  logic [KEY_W-1:0] one_init, acc_upd;

  // both multipliers start together, so they finish together
  assign mm_done = mm0_done && mm1_done;

  // 1 mod n
  assign one_init = (req_i.modulus == KEY_W'(1)) ? '0 : KEY_W'(1);
  assign acc_upd  = exp_q[0] ? mm0_prod : acc_q;

  always_comb begin
    mm_start = 1'b0;
    mm0_a    = req_i.message;
    mm0_b    = one_init;
    mm1_a    = mm0_prod;
    mm1_b    = mm0_prod;
    mm_n     = n_q;
    case (state_q)
      ME_IDLE: begin
        // message * 1 mod n reduces the message
        mm_start = start_i && !req_i.zero;
        mm_n     = req_i.modulus;
      end
      ME_REDUCE: begin
        mm_start = mm_done;
        mm0_a    = one_q;
        mm0_b    = mm0_prod;
      end
      ME_EXP: begin
        mm_start = mm_done && (cnt_q != CNT_MAX);
        mm0_a    = acc_upd;
        mm0_b    = mm1_prod;
        mm1_a    = mm1_prod;
        mm1_b    = mm1_prod;
      end
      default: ;
    endcase
  end

  rsa_modmul u_mul_acc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mm_start),
    .a_i     (mm0_a),
    .b_i     (mm0_b),
    .n_i     (mm_n),
    .done_o  (mm0_done),
    .prod_o  (mm0_prod)
  );

  rsa_modmul u_mul_sqr (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mm_start),
    .a_i     (mm1_a),
    .b_i     (mm1_b),
    .n_i     (mm_n),
    .done_o  (mm1_done),
    .prod_o  (mm1_prod)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ME_IDLE;
      cnt_q    <= '0;
      result_q <= '0;
    end else begin
      unique case (state_q)
        ME_IDLE: begin
          if (start_i) begin
            if (req_i.zero) begin
              result_q <= '0;
              state_q  <= ME_DONE;
            end else begin
              state_q <= ME_REDUCE;
            end
          end
        end
        ME_REDUCE: begin
          if (mm_done) begin
            cnt_q   <= '0;
            state_q <= ME_EXP;
          end
        end
        ME_EXP: begin
          if (mm_done) begin
            cnt_q <= cnt_q + 1'b1;
            if (cnt_q == CNT_MAX) begin
              result_q <= acc_upd;
              state_q  <= ME_DONE;
            end
          end
        end
        ME_DONE: begin
          if (res_ready_i) begin
            state_q <= ME_IDLE;
          end
        end
        default: state_q <= ME_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ME_IDLE: begin
        if (start_i) begin
          n_q   <= req_i.modulus;
          one_q <= one_init;
          exp_q <= req_i.exponent;
        end
      end
      ME_REDUCE: begin
        if (mm_done) begin
          acc_q <= one_q;
        end
      end
      ME_EXP: begin
        if (mm_done) begin
          acc_q <= acc_upd;
          exp_q <= {1'b0, exp_q[KEY_W-1:1]};
        end
      end
      default: ;
    endcase
  end

  assign idle_o      = (state_q == ME_IDLE);
  assign res_valid_o = (state_q == ME_DONE);
  assign result_o    = result_q;

endmodule

// ----- hdl/rsa_encrypt_decrypt_top.sv -----
// Textbook RSA engine. After reset and after every write to a prime or the
// public exponent, the block derives n = p*q and d = e^-1 mod (p-1)(q-1)
// by a bit-serial Euclid (at most about 50 steps for 32-bit values), and no
// request is accepted meanwhile. Each request then takes one modular multiply
// to reduce the message plus 32 rounds of square and multiply on bit-serial
// modular multipliers that retire one multiplier bit per cycle (the square
// and the multiply run side by side). Decrypt with a missing inverse, or
// n = 0, skips the computation: the engine goes straight to its done state
// and hands a zero result to the output register. One request is in work
// at a time; a new one is taken while the previous response waits in the
// output register.
// Depends on rsa_pkg, rsa_keygen, rsa_modexp.
module rsa_encrypt_decrypt_top import rsa_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  // request channel
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              mode_i,
  input  logic [KEY_W-1:0]  message_i,
  // response channel
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [KEY_W-1:0]  result_o,
  output logic              key_error_o
);

  logic [CFG_PRIME_W-1:0] prime_p_q, prime_q_q;
  logic [KEY_W-1:0]       pub_exp_q;
  logic                   derive_q;
  logic                   out_valid_q, key_error_q, kerr_q;
  logic [KEY_W-1:0]       result_q;

  logic       cfg_wr, cfg_known, in_acc;
  logic [1:0] cfg_idx;
  keys_t      keys;
  exp_req_t   req;
  logic       eng_idle, eng_valid, eng_ready;
  logic [KEY_W-1:0] eng_result;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[3:2];

  always_comb begin
    unique case (cfg_idx)
      REG_PRIME_P: begin
        cfg_known = 1'b1;
        prdata    = DATA_W'(prime_p_q);
      end
      REG_PRIME_Q: begin
        cfg_known = 1'b1;
        prdata    = DATA_W'(prime_q_q);
      end
      REG_PUB_EXP: begin
        cfg_known = 1'b1;
        prdata    = DATA_W'(pub_exp_q);
      end
      default: begin
        cfg_known = 1'b0;
        prdata    = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prime_p_q <= RESET_PRIME_P;
      prime_q_q <= RESET_PRIME_Q;
      pub_exp_q <= RESET_PUB_EXP;
      derive_q  <= 1'b1;
    end else begin
      derive_q <= cfg_wr && cfg_known;
      if (cfg_wr) begin
        unique case (cfg_idx)
          REG_PRIME_P: prime_p_q <= pwdata[CFG_PRIME_W-1:0];
          REG_PRIME_Q: prime_q_q <= pwdata[CFG_PRIME_W-1:0];
          REG_PUB_EXP: pub_exp_q <= pwdata[KEY_W-1:0];
          default: ;
        endcase
      end
    end
  end

  rsa_keygen u_keygen (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (derive_q),
    .prime_p_i (prime_p_q),
    .prime_q_i (prime_q_q),
    .pub_exp_i (pub_exp_q),
    .keys_o    (keys)
  );

  assign in_ready_o = !derive_q && !keys.busy && eng_idle;
  assign in_acc     = in_valid_i && in_ready_o;

  assign req.message  = message_i;
  assign req.exponent = (mode_i == MODE_DECRYPT) ? keys.priv_exp : pub_exp_q;
  assign req.modulus  = keys.modulus;
  assign req.zero     = (keys.modulus == '0) ||
                        ((mode_i == MODE_DECRYPT) && keys.inv_missing);

  rsa_modexp u_modexp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_acc),
    .req_i       (req),
    .idle_o      (eng_idle),
    .res_valid_o (eng_valid),
    .res_ready_i (eng_ready),
    .result_o    (eng_result)
  );

  assign eng_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      kerr_q <= (mode_i == MODE_DECRYPT) && keys.inv_missing;
    end
    if (eng_valid && eng_ready) begin
      result_q    <= eng_result;
      key_error_q <= kerr_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (eng_valid && eng_ready) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;
  assign key_error_o = key_error_q;

`ifndef NO_ASSERTIONS
  // an accepted request occupies the engine
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_o)
    else $error("request accepted while engine busy");

  // a key change blocks requests until derivation ends
  a_cfg_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr && cfg_known |=> !in_ready_o)
    else $error("request window open during key derivation");

  // a key error always carries a zero result
  a_kerr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && key_error_o |-> result_o == '0)
    else $error("key error with nonzero result");

  // the engine hands over a result only into a free output slot
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i && eng_valid |=> $stable(result_q))
    else $error("pending response overwritten");
`endif

endmodule
